// ----- sv/udp_port_demux_queues_unit_macros.svh -----
// Assertion macros shared by the UDP port demultiplexer RTL.
`ifndef UDP_PORT_DEMUX_QUEUES_UNIT_MACROS_SVH
`define UDP_PORT_DEMUX_QUEUES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define UDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("udq assertion failed");
// Next-cycle implication, checked out of reset.
`define UDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("udq assertion failed");
`else
`define UDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/udq_pkg.sv -----
// Package with beat types, codes and control types of the UDP port demultiplexer.
package udq_pkg;

  // Command codes.
  localparam logic [1:0] CMD_BIND     = 2'd0;
  localparam logic [1:0] CMD_FRAME    = 2'd1;
  localparam logic [1:0] CMD_RECV     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Status codes.
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_REFUSED  = 3'd1;
  localparam logic [2:0] STAT_UNBOUND  = 3'd2;
  localparam logic [2:0] STAT_EMPTY    = 3'd3;
  localparam logic [2:0] STAT_DROPPED  = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;
  localparam logic [2:0] STAT_ARP      = 3'd6;

  // Protocol constants.
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [15:0] HDR_BYTES  = 16'd28;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] port;
    logic [15:0] ethertype;
    logic [7:0]  ip_proto;
    logic [15:0] dst_port;
    logic [31:0] src_addr;
    logic [15:0] peer_port;
    logic [15:0] ip_total_len;
    logic [11:0] frame_handle;
    logic [15:0] max_len;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] out_src_addr;
    logic [15:0] out_peer_port;
    logic [11:0] out_handle;
    logic [15:0] data_len;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_LOOKUP,
    S_QUEUE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic match_en;
    logic lookup_en;
    logic queue_en;
    logic read_en;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

// ----- sv/udq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module udq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/udq_ctrl.sv -----
// Sequencer of the UDP port demultiplexer.
module udq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                out_stall,
  input  udq_pkg::dp_status_t dp_stat,
  output udq_pkg::ctl_cmd_t   cmd,
  output udq_pkg::state_t     state
);
  import udq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_free;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !dp_stat.out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_MATCH;
      S_MATCH:  state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_QUEUE;
      S_QUEUE:  state_nxt = S_READ;
      S_READ:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_MATCH:  cmd.match_en  = 1'b1;
      S_LOOKUP: cmd.lookup_en = 1'b1;
      S_QUEUE:  cmd.queue_en  = 1'b1;
      S_READ:   cmd.read_en   = 1'b1;
      S_DONE:   cmd.out_load  = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;
endmodule

// ----- sv/udq_dp.sv -----
// Datapath of the UDP port demultiplexer: socket table, queue pointers and queue store.
module udq_dp #(
  parameter int NUM_SOCKETS = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  udq_pkg::ctl_cmd_t   cmd,
  output udq_pkg::dp_status_t dp_stat,
  input  udq_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output udq_pkg::out_beat_t  out_beat
);
  import udq_pkg::*;

  localparam int SW    = NUM_SOCKETS > 1 ? $clog2(NUM_SOCKETS) : 1;
  localparam int QW    = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW  = CW + 1;
  localparam int HB    = HANDLE_BITS < 12 ? HANDLE_BITS : 12;
  localparam int DW    = 32 + 16 + HB + 16;
  localparam int HCW   = QW + CW;
  localparam int DDEP  = NUM_SOCKETS * QUEUE_DEPTH;
  localparam int DAW   = DDEP > 1 ? $clog2(DDEP) : 1;

  in_beat_t               item_r;
  logic [NUM_SOCKETS-1:0] in_use_r;
  logic [15:0]            port_r [NUM_SOCKETS];
  logic [NUM_SOCKETS-1:0] match_c, match_r, free_r;
  logic [15:0]            key;

  logic                   hit_c, free_c;
  logic [SW-1:0]          hit_slot_c, free_slot_c;

  logic [2:0]             pre_stat;
  logic [SW-1:0]          pre_slot;
  logic                   pre_pend, bind_wr;
  logic [2:0]             stat_r;
  logic [SW-1:0]          slot_r;
  logic                   pend_r;

  logic                   hc_we;
  logic [SW-1:0]          hc_waddr;
  logic [HCW-1:0]         hc_wdata, hc_rdata;
  logic [QW-1:0]          head, head_inc, pos;
  logic [CW-1:0]          cnt;
  logic [SUMW-1:0]        sum;
  logic [DAW-1:0]         base, d_waddr, d_raddr;
  logic                   d_we;
  logic [DW-1:0]          d_wdata, d_rdata;
  logic                   q_hc_we;
  logic [HCW-1:0]         q_hc_wdata;
  logic [2:0]             q_stat;
  logic                   q_deq;
  logic                   deq_r;

  out_beat_t              res_r;
  out_beat_t              out_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [SW+3:0]          slot_ext;
  logic [15:0]            tlen, plen;
  logic [HB-1:0]          hnd;

  // Input beat capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_beat;
    end
  end

  // Port compare against every bound slot.
  assign key = (item_r.cmd == CMD_FRAME) ? item_r.dst_port : item_r.port;

  always_comb begin
    for (int i = 0; i < NUM_SOCKETS; i++) begin
      match_c[i] = in_use_r[i] && (port_r[i] == key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      match_r <= match_c;
      free_r  <= ~in_use_r;
    end
  end

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit_c       = 1'b0;
    hit_slot_c  = '0;
    free_c      = 1'b0;
    free_slot_c = '0;
    for (int i = NUM_SOCKETS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_c      = 1'b1;
        hit_slot_c = SW'(i);
      end
      if (free_r[i]) begin
        free_c      = 1'b1;
        free_slot_c = SW'(i);
      end
    end
  end

  // First decision: bind outcome, filtering and port lookup.
  always_comb begin
    pre_stat = STAT_DROPPED;
    pre_slot = '0;
    pre_pend = 1'b0;
    bind_wr  = 1'b0;
    case (item_r.cmd)
      CMD_BIND: begin
        if (hit_c) begin
          pre_stat = STAT_REFUSED;
          pre_slot = hit_slot_c;
        end else if (free_c) begin
          pre_stat = STAT_OK;
          pre_slot = free_slot_c;
          bind_wr  = 1'b1;
        end else begin
          pre_stat = STAT_REFUSED;
        end
      end
      CMD_FRAME: begin
        if (item_r.ethertype == ETYPE_ARP) begin
          pre_stat = STAT_ARP;
        end else if (item_r.ethertype != ETYPE_IPV4 || item_r.ip_proto != PROTO_UDP) begin
          pre_stat = STAT_DROPPED;
        end else if (!hit_c) begin
          pre_stat = STAT_UNBOUND;
        end else begin
          pre_slot = hit_slot_c;
          pre_pend = 1'b1;
        end
      end
      CMD_RECV: begin
        if (!hit_c) begin
          pre_stat = STAT_UNBOUND;
        end else begin
          pre_slot = hit_slot_c;
          pre_pend = 1'b1;
        end
      end
      default: pre_stat = STAT_DROPPED;
    endcase
  end

  // Decision registers: the lookup step sets them, the queue step refines the status.
  always_ff @(posedge clk) begin
    if (cmd.lookup_en) begin
      stat_r <= pre_stat;
      slot_r <= pre_slot;
      pend_r <= pre_pend;
    end else if (cmd.queue_en) begin
      stat_r <= q_stat;
      deq_r  <= q_deq;
    end
  end

  // Socket table: bound flags are reset, ports are written on bind.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cmd.lookup_en && bind_wr) begin
      in_use_r[free_slot_c] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_en && bind_wr) begin
      port_r[free_slot_c] <= item_r.port;
    end
  end

  // Queue head and count per slot; a bind clears them.
  assign hc_we    = (cmd.lookup_en && bind_wr) || (cmd.queue_en && q_hc_we);
  assign hc_waddr = cmd.lookup_en ? free_slot_c : slot_r;
  assign hc_wdata = cmd.lookup_en ? '0 : q_hc_wdata;

  udq_ram #(.WIDTH(HCW), .DEPTH(NUM_SOCKETS)) u_hc_ram (
    .clk   (clk),
    .we    (hc_we),
    .waddr (hc_waddr),
    .wdata (hc_wdata),
    .raddr (hit_slot_c),
    .rdata (hc_rdata)
  );

  // Ring arithmetic for the matched queue.
  assign head     = hc_rdata[HCW-1:CW];
  assign cnt      = hc_rdata[CW-1:0];
  assign sum      = SUMW'(head) + SUMW'(cnt);
  assign pos      = (sum >= SUMW'(QUEUE_DEPTH)) ? QW'(sum - SUMW'(QUEUE_DEPTH)) : QW'(sum);
  assign head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign base     = DAW'(slot_r) * DAW'(QUEUE_DEPTH);
  assign d_waddr  = base + DAW'(pos);
  assign d_raddr  = base + DAW'(head);
  assign hnd      = HB'(item_r.frame_handle);
  assign d_wdata  = {item_r.src_addr, item_r.peer_port, hnd, item_r.ip_total_len};

  // Second decision: enqueue or dequeue on the matched queue.
  always_comb begin
    q_stat     = stat_r;
    q_hc_we    = 1'b0;
    q_hc_wdata = hc_rdata;
    q_deq      = 1'b0;
    d_we       = 1'b0;
    if (pend_r) begin
      if (item_r.cmd == CMD_FRAME) begin
        if (cnt >= CW'(QUEUE_DEPTH)) begin
          q_stat = STAT_FULL;
        end else begin
          q_stat     = STAT_OK;
          d_we       = cmd.queue_en;
          q_hc_we    = 1'b1;
          q_hc_wdata = {head, cnt + 1'b1};
        end
      end else begin
        if (cnt == '0) begin
          q_stat = STAT_EMPTY;
        end else begin
          q_stat     = STAT_OK;
          q_deq      = 1'b1;
          q_hc_we    = 1'b1;
          q_hc_wdata = {head_inc, cnt - 1'b1};
        end
      end
    end
  end

  udq_ram #(.WIDTH(DW), .DEPTH(DDEP)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  // Payload length: total length less the headers, floored at zero, capped.
  always_comb begin
    tlen = d_rdata[15:0];
    plen = (tlen > HDR_BYTES) ? tlen - HDR_BYTES : '0;
    if (plen > item_r.max_len) begin
      plen = item_r.max_len;
    end
  end

  assign slot_ext = {4'b0, slot_r};

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      res_r.status <= stat_r;
      res_r.slot   <= slot_ext[3:0];
      if (deq_r) begin
        res_r.out_src_addr  <= d_rdata[DW-1 -: 32];
        res_r.out_peer_port <= d_rdata[DW-33 -: 16];
        res_r.out_handle    <= 12'(d_rdata[16 +: HB]);
        res_r.data_len      <= plen;
      end else begin
        res_r.out_src_addr  <= '0;
        res_r.out_peer_port <= '0;
        res_r.out_handle    <= '0;
        res_r.data_len      <= '0;
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_beat          = out_r;
  assign dp_stat.out_valid = out_valid_r;
endmodule

// ----- sv/udp_port_demux_queues_unit.sv -----
// Top level of the UDP port demultiplexer with per-socket receive queues.
// The result beat passes through the match, lookup, queue, read and done steps to the output register.
// The six-state sequencer works on one item at a time; a new beat is taken only back in idle.
// A result beat waiting on out_stall holds the sequencer only at its final step.
// Reset clears the bound flags, the sequencer and the output valid; no clearing pass.
`include "udp_port_demux_queues_unit_macros.svh"
module udp_port_demux_queues_unit #(
  parameter int NUM_SOCKETS = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  udq_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output udq_pkg::out_beat_t out_beat
);
  import udq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t dp_stat;
  state_t     state;

  udq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .cmd       (cmd),
    .state     (state)
  );

  udq_dp #(
    .NUM_SOCKETS (NUM_SOCKETS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .dp_stat   (dp_stat),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // An accepted beat keeps the block busy on the next cycle.
  `UDQ_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // A result beat appears only out of the final sequencer step.
  `UDQ_ASSERT_IMP(a_out_from_done, clk, rst_n, $rose(out_valid), $past(state) == S_DONE)
  // The sequencer leaves its final step only by loading the output register.
  `UDQ_ASSERT_NXT(a_done_loads, clk, rst_n, cmd.out_load, out_valid && state == S_IDLE)
endmodule

// ----- verif/tb.sv -----
// Self-checking testbench of the UDP port demultiplexer with per-socket receive queues.
`timescale 1ns / 1ps
module tb;
  import udq_pkg::*;

  localparam int SOCKETS = 16;
  localparam int QDEPTH = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  // Scoreboard: a copy of the socket table and queues, and the results it predicts.
  class socket_scoreboard;
    bit          bound[SOCKETS];
    logic [15:0] bound_port[SOCKETS];
    logic [31:0] q_addr[SOCKETS][QDEPTH];
    logic [15:0] q_sport[SOCKETS][QDEPTH];
    logic [11:0] q_handle[SOCKETS][QDEPTH];
    logic [15:0] q_tlen[SOCKETS][QDEPTH];
    int          q_head[SOCKETS];
    int          q_count[SOCKETS];
    out_beat_t   pending[$];
    int          errors;

    function int lookup(logic [15:0] p);
      for (int i = 0; i < SOCKETS; i++)
        if (bound[i] && bound_port[i] == p) return i;
      return -1;
    endfunction

    // Works out the result of one accepted input beat and updates the state.
    function void note_input(in_beat_t b);
      out_beat_t r;
      int s;
      int pos;
      logic [15:0] plen;
      r = '0;
      r.status = STAT_DROPPED;
      case (b.cmd)
        CMD_BIND: begin
          s = lookup(b.port);
          if (s >= 0) begin
            r.status = STAT_REFUSED;
            r.slot = s[3:0];
          end else begin
            r.status = STAT_REFUSED;
            for (int i = 0; i < SOCKETS; i++) begin
              if (!bound[i]) begin
                bound[i] = 1;
                bound_port[i] = b.port;
                q_head[i] = 0;
                q_count[i] = 0;
                r.status = STAT_OK;
                r.slot = i[3:0];
                break;
              end
            end
          end
        end
        CMD_FRAME: begin
          if (b.ethertype == ETYPE_ARP) r.status = STAT_ARP;
          else if (b.ethertype != ETYPE_IPV4 || b.ip_proto != PROTO_UDP)
            r.status = STAT_DROPPED;
          else begin
            s = lookup(b.dst_port);
            if (s < 0) r.status = STAT_UNBOUND;
            else if (q_count[s] >= QDEPTH) begin
              r.status = STAT_FULL;
              r.slot = s[3:0];
            end else begin
              pos = (q_head[s] + q_count[s]) % QDEPTH;
              q_addr[s][pos] = b.src_addr;
              q_sport[s][pos] = b.peer_port;
              q_handle[s][pos] = b.frame_handle;
              q_tlen[s][pos] = b.ip_total_len;
              q_count[s]++;
              r.status = STAT_OK;
              r.slot = s[3:0];
            end
          end
        end
        CMD_RECV: begin
          s = lookup(b.port);
          if (s < 0) r.status = STAT_UNBOUND;
          else if (q_count[s] == 0) begin
            r.status = STAT_EMPTY;
            r.slot = s[3:0];
          end else begin
            pos = q_head[s];
            plen = (q_tlen[s][pos] > HDR_BYTES) ? q_tlen[s][pos] - HDR_BYTES : 16'd0;
            if (plen > b.max_len) plen = b.max_len;
            r.status = STAT_OK;
            r.slot = s[3:0];
            r.out_src_addr = q_addr[s][pos];
            r.out_peer_port = q_sport[s][pos];
            r.out_handle = q_handle[s][pos];
            r.data_len = plen;
            q_head[s] = (q_head[s] + 1) % QDEPTH;
            q_count[s]--;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    // Compares one result beat with the oldest prediction.
    function void check_result(out_beat_t got);
      out_beat_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with no prediction waiting: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, actual %0d", exp_r.slot, got.slot);
        errors++;
      end
      if (got.out_src_addr !== exp_r.out_src_addr) begin
        $error("out_src_addr: expected %h, actual %h", exp_r.out_src_addr, got.out_src_addr);
        errors++;
      end
      if (got.out_peer_port !== exp_r.out_peer_port) begin
        $error("out_peer_port: expected %h, actual %h", exp_r.out_peer_port,
               got.out_peer_port);
        errors++;
      end
      if (got.out_handle !== exp_r.out_handle) begin
        $error("out_handle: expected %h, actual %h", exp_r.out_handle, got.out_handle);
        errors++;
      end
      if (got.data_len !== exp_r.data_len) begin
        $error("data_len: expected %0d, actual %0d", exp_r.data_len, got.data_len);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  socket_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  int quiet_cycles;
  logic [15:0] port_pool[8];

  udp_port_demux_queues_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_beat(in_beat),
    .out_valid(out_valid), .out_stall(out_stall), .out_beat(out_beat)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Sends one beat, with a random idle gap first, and waits for acceptance.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(b);
    @(negedge clk);
  endtask

  function automatic in_beat_t frame_beat(logic [15:0] dport);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    b.cmd = CMD_FRAME;
    b.ethertype = ETYPE_IPV4;
    b.ip_proto = PROTO_UDP;
    b.dst_port = dport;
    if ($urandom_range(3) == 0) b.ip_total_len = 16'($urandom_range(40));
    return b;
  endfunction

  function automatic in_beat_t call_beat(logic [1:0] c, logic [15:0] p);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    b.cmd = c;
    b.port = p;
    if ($urandom_range(2) == 0) b.max_len = 16'($urandom_range(64));
    return b;
  endfunction

  // Picks a beat: mostly traffic to a small set of ports, with some noise.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    logic [15:0] p;
    int k;
    p = port_pool[$urandom_range(7)];
    k = $urandom_range(99);
    if (k < 8) b = call_beat(CMD_BIND, p);
    else if (k < 50) b = frame_beat(p);
    else if (k < 85) b = call_beat(CMD_RECV, p);
    else begin
      b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if (k < 90) b.ethertype = ETYPE_ARP;
      else if (k < 94) b.ethertype = ETYPE_IPV4;
    end
    return b;
  endfunction

  // Receiver: random stall, or a long hold-off when asked.
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Result monitor and no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_beat);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("udp_port_demux_queues_unit regression: fail");
        $finish;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering beats.
  initial begin
    hold_off = 0;
    wait (rst_n);
    repeat (700) @(negedge clk);
    hold_off = 1;
    repeat (300) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    in_beat_t b;
    int n;
    sb = new();
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_valid = 0;
    in_beat = '0;
    out_stall = 0;
    rst_n = 0;
    for (int i = 0; i < 8; i++) port_pool[i] = 16'($urandom);
    port_pool[0] = 16'h0000;
    port_pool[1] = 16'hFFFF;
    port_pool[2] = 16'h8000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: unbound traffic, binds, duplicates, ARP, non-UDP, unused code, length and cap edges.
    send_beat(call_beat(CMD_RECV, 16'hFFFF));
    send_beat(frame_beat(16'h8000));
    send_beat(call_beat(CMD_BIND, 16'hFFFF));
    send_beat(call_beat(CMD_BIND, 16'hFFFF));
    send_beat(call_beat(CMD_RECV, 16'hFFFF));
    b = frame_beat(16'hFFFF);
    b.ethertype = ETYPE_ARP;
    send_beat(b);
    b = frame_beat(16'hFFFF);
    b.ip_proto = PROTO_TCP;
    send_beat(b);
    b = frame_beat(16'hFFFF);
    b.ethertype = ETYPE_IPV6;
    send_beat(b);
    b = call_beat(CMD_RESERVED, 16'hFFFF);
    send_beat(b);
    b = frame_beat(16'hFFFF);
    b.ip_total_len = 16'd27;
    b.src_addr = 32'hFFFFFFFF;
    b.frame_handle = 12'hFFF;
    send_beat(b);
    b = frame_beat(16'hFFFF);
    b.ip_total_len = 16'hFFFF;
    send_beat(b);
    b = call_beat(CMD_RECV, 16'hFFFF);
    b.max_len = 16'hFFFF;
    send_beat(b);
    b = call_beat(CMD_RECV, 16'hFFFF);
    b.max_len = 16'd0;
    send_beat(b);
    // Fill one queue past its depth, then fill the socket table.
    for (int i = 0; i < QDEPTH + 1; i++) send_beat(frame_beat(16'hFFFF));
    for (int i = 0; i < SOCKETS; i++) send_beat(call_beat(CMD_BIND, 16'(i)));
    send_beat(frame_beat(16'd0));
    send_beat(call_beat(CMD_RECV, 16'd0));

    // Random phases over the idling mixes.
    n = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 18 : 53) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 18 : 53) : 0;
      for (int i = 0; i < 100; i++) send_beat(random_beat());
    end

    in_valid <= 1'b0;
    n = 0;
    while (sb.pending.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("udp_port_demux_queues_unit regression: pass");
    else
      $display("udp_port_demux_queues_unit regression: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+sv
sv/udq_pkg.sv
sv/udq_ram.sv
sv/udq_ctrl.sv
sv/udq_dp.sv
sv/udp_port_demux_queues_unit.sv
verif/tb.sv
